### rtl/abl_pkg.sv
`timescale 1ns / 1ps
package abl_pkg;

   // Longest word held before it is forced out
   localparam int WORD_MAX = 31;
   localparam int WORD_AW  = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
   localparam int LEN_W    = $clog2(WORD_MAX + 1);

   // Command queue between classifier and emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Token codes on the result channel
   localparam logic [3:0] KIND_DOT     = 4'd0;
   localparam logic [3:0] KIND_COMMA   = 4'd1;
   localparam logic [3:0] KIND_COLON   = 4'd2;
   localparam logic [3:0] KIND_LPAREN  = 4'd3;
   localparam logic [3:0] KIND_RPAREN  = 4'd4;
   localparam logic [3:0] KIND_DOLLAR  = 4'd5;
   localparam logic [3:0] KIND_PERCENT = 4'd6;
   localparam logic [3:0] KIND_EOL     = 4'd7;
   localparam logic [3:0] KIND_WORD    = 4'd8;
   localparam logic [3:0] KIND_END     = 4'd9;

   // One classified input byte, carried out in field order:
   // lead EOL, word flush, first token, END token, then store of chr.
   typedef struct packed {
      logic       lead_eol;
      logic       flush;
      logic       tok1;
      logic [3:0] tok1_kind;
      logic       tok2;
      logic       store;
      logic [7:0] chr;
   } cmd_type;

endpackage

### rtl/abl_front.sv
`timescale 1ns / 1ps
module abl_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             end_of_input,
   output logic             cmd_push,
   output abl_pkg::cmd_type cmd
);
   import abl_pkg::*;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_DOLL  = 8'h24;
   localparam logic [7:0] CH_PCT   = 8'h25;

   logic             comment_ff, comment_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             is_space, is_special;
   logic [3:0]       spec_kind;
   logic             word_open, extend;

   // Byte classes
   always_comb begin
      is_special = 1'b1;
      spec_kind  = KIND_DOT;
      case (in_byte)
         CH_DOT:   spec_kind = KIND_DOT;
         CH_COMMA: spec_kind = KIND_COMMA;
         CH_COLON: spec_kind = KIND_COLON;
         CH_LPAR:  spec_kind = KIND_LPAREN;
         CH_RPAR:  spec_kind = KIND_RPAREN;
         CH_DOLL:  spec_kind = KIND_DOLLAR;
         CH_PCT:   spec_kind = KIND_PERCENT;
         default:  is_special = 1'b0;
      endcase
      is_space = (in_byte inside {CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_VT, CH_FF});
   end

   assign word_open = (len_ff != '0);
   assign extend    = word_open && !is_space && !is_special
                      && (len_ff < LEN_W'(WORD_MAX));

   // Command build and lexer state update
   always_comb begin
      cmd        = '0;
      cmd.chr    = in_byte;
      comment_in = comment_ff;
      len_in     = len_ff;
      if (end_of_input) begin
         cmd.lead_eol  = comment_ff;
         cmd.flush     = word_open;
         cmd.tok1      = 1'b1;
         cmd.tok1_kind = KIND_EOL;
         cmd.tok2      = 1'b1;
         comment_in    = 1'b0;
         len_in        = '0;
      end else if (comment_ff) begin
         if (in_byte == CH_NL) begin
            cmd.tok1      = 1'b1;
            cmd.tok1_kind = KIND_EOL;
            comment_in    = 1'b0;
         end
      end else if (extend) begin
         cmd.store = 1'b1;
         len_in    = len_ff + LEN_W'(1);
      end else begin
         cmd.flush = word_open;
         len_in    = '0;
         if (in_byte == CH_SPACE || in_byte == CH_TAB) begin
            // skipped
         end else if (in_byte == CH_SEMI) begin
            comment_in = 1'b1;
         end else if (is_special) begin
            cmd.tok1      = 1'b1;
            cmd.tok1_kind = spec_kind;
         end else if (in_byte == CH_NL) begin
            cmd.tok1      = 1'b1;
            cmd.tok1_kind = KIND_EOL;
         end else begin
            cmd.store = 1'b1;
            len_in    = LEN_W'(1);
         end
      end
   end

   // Bytes that neither emit nor store are dropped here
   assign cmd_push = accept && (cmd.lead_eol || cmd.flush || cmd.tok1 || cmd.tok2
                                || cmd.store);

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_ff <= 1'b0;
         len_ff     <= '0;
      end else if (accept) begin
         comment_ff <= comment_in;
         len_ff     <= len_in;
      end
   end

endmodule

### rtl/abl_queue.sv
`timescale 1ns / 1ps
module abl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  abl_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_vld,
   output abl_pkg::cmd_type head_cmd
);
   import abl_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]      count_ff;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign head_vld = (count_ff != '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && head_vld;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         if (do_push && !do_pop)      count_ff <= count_ff + (QUEUE_AW + 1)'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - (QUEUE_AW + 1)'(1);
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

### rtl/abl_back.sv
`timescale 1ns / 1ps
module abl_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_vld,
   input  abl_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             out_vld,
   input  logic             out_rdy,
   output logic [3:0]       out_kind,
   output logic [7:0]       out_char,
   output logic [5:0]       out_index,
   output logic             out_done,
   output logic             out_last
);
   import abl_pkg::*;

   logic [7:0]         word_mem [WORD_MAX];
   cmd_type            cur_ff, cur_in;
   logic               cur_vld_ff, cur_vld_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [WORD_AW-1:0] idx_ff, idx_in;

   logic               out_vld_ff;
   logic [3:0]         kind_ff;
   logic [7:0]         char_ff;
   logic [5:0]         index_ff;
   logic               done_ff, last_ff;

   logic               slot_free, any_out, emit, retire, last_char;
   logic               emit_word;
   logic [3:0]         emit_kind;
   logic               emit_done, emit_last;

   assign slot_free = !out_vld_ff || out_rdy;
   assign any_out   = cur_ff.lead_eol || cur_ff.flush || cur_ff.tok1 || cur_ff.tok2;
   assign emit      = cur_vld_ff && any_out && slot_free;
   assign retire    = cur_vld_ff && !any_out;
   assign pop       = head_vld && (!cur_vld_ff || retire);
   assign last_char = ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);

   // Pick the next result of the current command; tokens go out in fixed order
   always_comb begin
      cur_in     = cur_ff;
      cur_vld_in = cur_vld_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      emit_word  = 1'b0;
      emit_kind  = KIND_EOL;
      emit_done  = 1'b0;
      emit_last  = 1'b0;
      if (emit) begin
         if (cur_ff.lead_eol) begin
            emit_kind       = KIND_EOL;
            emit_last       = !(cur_ff.flush || cur_ff.tok1 || cur_ff.tok2);
            cur_in.lead_eol = 1'b0;
         end else if (cur_ff.flush) begin
            emit_word = 1'b1;
            emit_kind = KIND_WORD;
            emit_done = last_char;
            emit_last = last_char && !(cur_ff.tok1 || cur_ff.tok2);
            if (last_char) begin
               cur_in.flush = 1'b0;
               len_in       = '0;
               idx_in       = '0;
            end else begin
               idx_in = idx_ff + WORD_AW'(1);
            end
         end else if (cur_ff.tok1) begin
            emit_kind   = cur_ff.tok1_kind;
            emit_last   = !cur_ff.tok2;
            cur_in.tok1 = 1'b0;
         end else begin
            emit_kind   = KIND_END;
            emit_last   = 1'b1;
            cur_in.tok2 = 1'b0;
         end
      end
      // Word append happens as the command retires
      if (retire) begin
         cur_vld_in = 1'b0;
         if (cur_ff.store) len_in = len_ff + LEN_W'(1);
      end
      if (pop) begin
         cur_vld_in = 1'b1;
         cur_in     = head_cmd;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         len_ff     <= '0;
         idx_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
         if (emit)          out_vld_ff <= 1'b1;
         else if (out_rdy)  out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Word store write and registered read into the output word
   always_ff @(posedge clock) begin
      if (retire && cur_ff.store) word_mem[len_ff[WORD_AW-1:0]] <= cur_ff.chr;
      if (emit) begin
         kind_ff  <= emit_kind;
         char_ff  <= emit_word ? word_mem[idx_ff] : 8'd0;
         index_ff <= emit_word ? 6'(idx_ff) : 6'd0;
         done_ff  <= emit_done;
         last_ff  <= emit_last;
      end
   end

   assign out_vld   = out_vld_ff;
   assign out_kind  = kind_ff;
   assign out_char  = char_ff;
   assign out_index = index_ff;
   assign out_done  = done_ff;
   assign out_last  = last_ff;

endmodule

### rtl/assembler_byte_lexer.sv
`timescale 1ns / 1ps
// Path: a byte that yields a token is registered in the command queue, then in the emitter's
// current command, then in the output register behind rsp_tvalid; queued commands ahead of it hold it back.
// Throughput: one byte per cycle while the 4-entry command queue has room. The emitter
// retires each queued command on its own and sends a word as one result per character;
// blanks and comment bytes that neither close a word nor end a comment never reach it.
// Reset (synchronous, active high) clears comment state, word length, queue and emitter.
module assembler_byte_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [0:0]  req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] text_char, [13:8] char_index, [14] word_done
   output logic [3:0]  rsp_tuser,   // [3:0] token_kind
   output logic        rsp_tlast    // run_last
);
   import abl_pkg::*;

   logic       accept, cmd_push, q_full, q_pop, head_vld;
   cmd_type    cmd, head_cmd;
   logic [7:0] out_char;
   logic [5:0] out_index;
   logic       out_done;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   abl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_tdata),
      .end_of_input (req_tuser[0]),
      .cmd_push     (cmd_push),
      .cmd          (cmd)
   );

   abl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_vld (head_vld),
      .head_cmd (head_cmd)
   );

   abl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_vld  (head_vld),
      .head_cmd  (head_cmd),
      .pop       (q_pop),
      .out_vld   (rsp_tvalid),
      .out_rdy   (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_char  (out_char),
      .out_index (out_index),
      .out_done  (out_done),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_done, out_index, out_char};

endmodule
